@@ rtl/tpc_pkg.sv @@
`default_nettype none
package tpc_pkg;

    localparam int DIV_W = 32;

    localparam logic [1:0] REG_TEMP_COEFFS = 2'd0;
    localparam logic [1:0] REG_PRES_A      = 2'd1;
    localparam logic [1:0] REG_PRES_B      = 2'd2;
    localparam logic [1:0] REG_PRES_NINE   = 2'd3;

    // side data that rides along the divider
    typedef struct packed {
        logic [31:0] temp;
        logic        dbl;
        logic        zero;
    } t_div_tag;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // arithmetic shift right of a 32-bit word, sign kept whatever the context
    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
        return $signed(x) >>> n;
    endfunction

endpackage
`default_nettype wire

@@ rtl/tpc_div.sv @@
`default_nettype none
module tpc_div
    import tpc_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  wire [DIV_W-1:0]  i_num,
    input  wire [DIV_W-1:0]  i_den,
    input  t_div_tag         i_tag,
    output logic             o_valid,
    output logic [DIV_W-1:0] o_quot,
    output t_div_tag         o_tag
);

    // one quotient bit per stage, restoring
    logic             r_v   [1:DIV_W];
    logic [DIV_W-1:0] r_rem [1:DIV_W];
    logic [DIV_W-1:0] r_num [1:DIV_W];
    logic [DIV_W-1:0] r_q   [1:DIV_W];
    logic [DIV_W-1:0] r_den [1:DIV_W];
    t_div_tag         r_tag [1:DIV_W];

    genvar k;
    generate
        for (k = 1; k <= DIV_W; k++) begin : g_stage
            logic             p_v;
            logic [DIV_W-1:0] p_rem;
            logic [DIV_W-1:0] p_num;
            logic [DIV_W-1:0] p_q;
            logic [DIV_W-1:0] p_den;
            t_div_tag         p_tag;
            logic [DIV_W:0]   w_trial;
            logic [DIV_W:0]   w_diff;
            logic             w_ge;

            if (k == 1) begin : g_first
                assign p_v   = i_valid;
                assign p_rem = '0;
                assign p_num = i_num;
                assign p_q   = '0;
                assign p_den = i_den;
                assign p_tag = i_tag;
            end else begin : g_next
                assign p_v   = r_v[k-1];
                assign p_rem = r_rem[k-1];
                assign p_num = r_num[k-1];
                assign p_q   = r_q[k-1];
                assign p_den = r_den[k-1];
                assign p_tag = r_tag[k-1];
            end

            assign w_trial = {p_rem, p_num[DIV_W-1]};
            assign w_diff  = w_trial - {1'b0, p_den};
            assign w_ge    = !w_diff[DIV_W];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                    r_num[k] <= {p_num[DIV_W-2:0], 1'b0};
                    r_q[k]   <= {p_q[DIV_W-2:0], w_ge};
                    r_den[k] <= p_den;
                    r_tag[k] <= p_tag;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[DIV_W];
    assign o_quot  = r_q[DIV_W];
    assign o_tag   = r_tag[DIV_W];

endmodule
`default_nettype wire

@@ rtl/temp_pressure_compensation.sv @@
`default_nettype none
// Integer temperature and pressure compensation for a barometric sensor.
// Input stream: one beat carries a raw 20-bit temperature and a raw 20-bit
// pressure reading. Output stream: one beat per input beat, carrying
// temperature in 0.01 degC and pressure in Pa, with tuser set when the
// pressure divisor came out zero (pressure is then 0).
// Calibration coefficients sit in four registers on the APB port at byte
// addresses 0, 8, 16 and 24; write them only while the stream is idle.
// The path from input beat to output beat runs through 11 arithmetic
// stages, a 32-stage divider with one quotient bit per stage, 2 final stages
// and the output register. A new beat is taken every cycle unless the output stalls.
// A stall on the output freezes the whole pipeline; a one-beat skid
// register on the input keeps s_axis_tready a registered signal, so one
// beat is still taken in the cycle the stall starts.
// Reset clears the coefficients to zero and empties the pipeline.
module temp_pressure_compensation
    import tpc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [39:0] i_s_axis_tdata,   // adc_temperature[19:0], adc_pressure[39:20]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // temperature_centi[31:0], pressure_pa[63:32]
    output logic        o_m_axis_tuser,   // divisor_zero
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [47:0] r_tc;
    logic [63:0] r_pa;
    logic [63:0] r_pb;
    logic [15:0] r_p9;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
            r_pa <= '0;
            r_pb <= '0;
            r_p9 <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:3])
                REG_TEMP_COEFFS: r_tc <= pwdata[47:0];
                REG_PRES_A:      r_pa <= pwdata;
                REG_PRES_B:      r_pb <= pwdata;
                REG_PRES_NINE:   r_p9 <= pwdata[15:0];
                default:         r_p9 <= r_p9;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_TEMP_COEFFS: prdata = {16'd0, r_tc};
            REG_PRES_A:      prdata = r_pa;
            REG_PRES_B:      prdata = r_pb;
            REG_PRES_NINE:   prdata = {48'd0, r_p9};
            default:         prdata = '0;
        endcase
    end

    logic [31:0] c_t1, c_t2, c_t3, c_p1, c_p2, c_p3, c_p4;
    logic [31:0] c_p5, c_p6, c_p7, c_p8, c_p9;
    assign c_t1 = {16'd0, r_tc[15:0]};
    assign c_t2 = sx16(r_tc[31:16]);
    assign c_t3 = sx16(r_tc[47:32]);
    assign c_p1 = {16'd0, r_pa[15:0]};
    assign c_p2 = sx16(r_pa[31:16]);
    assign c_p3 = sx16(r_pa[47:32]);
    assign c_p4 = sx16(r_pa[63:48]);
    assign c_p5 = sx16(r_pb[15:0]);
    assign c_p6 = sx16(r_pb[31:16]);
    assign c_p7 = sx16(r_pb[47:32]);
    assign c_p8 = sx16(r_pb[63:48]);
    assign c_p9 = sx16(r_p9);

    // pipeline advance and input skid
    logic        w_adv;
    logic        r_o_v;
    logic        r_sk_v;
    logic [39:0] r_sk_d;
    logic        w_in_v;
    logic [39:0] w_in_d;

    assign w_adv           = !r_o_v || i_m_axis_tready;
    assign o_s_axis_tready = !r_sk_v;
    assign w_in_v          = r_sk_v || i_s_axis_tvalid;
    assign w_in_d          = r_sk_v ? r_sk_d : i_s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (w_adv) begin
            r_sk_v <= 1'b0;
        end else if (i_s_axis_tvalid && !r_sk_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_adv && i_s_axis_tvalid && !r_sk_v) begin
            r_sk_d <= i_s_axis_tdata;
        end
    end

    logic [10:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[9:0], w_in_v};
        end
    end

    logic [31:0] r1_x, r1_d;
    logic [19:0] r1_p, r2_p, r3_p, r4_p, r5_p, r6_p, r7_p, r8_p, r9_p;
    logic [31:0] r2_m1, r2_dd;
    logic [31:0] r3_a, r3_m2;
    logic [31:0] r4_fine;
    logic [31:0] r5_temp, r5_pa;
    logic [31:0] r6_temp, r6_sq, r6_m3, r6_m4;
    logic [31:0] r7_temp, r7_m6, r7_m5, r7_m3, r7_m4;
    logic [31:0] r8_temp, r8_b, r8_a;
    logic [31:0] r9_temp, r9_m, r9_b;
    logic [31:0] r10_temp, r10_den, r10_x;
    logic [31:0] r11_temp, r11_den, r11_pr;

    logic [31:0] w_adc_t, w_fine5, w_q, w_b7, w_s5, w_s4, w_x10;
    assign w_adc_t = {12'd0, w_in_d[19:0]};
    assign w_fine5 = (r4_fine << 2) + r4_fine + 32'd128;
    assign w_q     = $signed(r5_pa) >>> 2;
    assign w_b7    = r7_m6 + (r7_m3 << 1);
    assign w_s5    = $signed(r7_m5) >>> 3;
    assign w_s4    = $signed(r7_m4) >>> 1;
    assign w_x10   = 32'd1048576 - {12'd0, r9_p};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_x  <= (w_adc_t >> 3) - (c_t1 << 1);
            r1_d  <= (w_adc_t >> 4) - c_t1;
            r1_p  <= w_in_d[39:20];

            r2_m1 <= r1_x * c_t2;
            r2_dd <= r1_d * r1_d;
            r2_p  <= r1_p;

            r3_a  <= $signed(r2_m1) >>> 11;
            r3_m2 <= asr32(r2_dd, 5'd12) * c_t3;
            r3_p  <= r2_p;

            r4_fine <= r3_a + asr32(r3_m2, 5'd14);
            r4_p    <= r3_p;

            r5_temp <= $signed(w_fine5) >>> 8;
            r5_pa   <= asr32(r4_fine, 5'd1) - 32'd64000;
            r5_p    <= r4_p;

            r6_temp <= r5_temp;
            r6_sq   <= w_q * w_q;
            r6_m3   <= r5_pa * c_p5;
            r6_m4   <= c_p2 * r5_pa;
            r6_p    <= r5_p;

            r7_temp <= r6_temp;
            r7_m6   <= asr32(r6_sq, 5'd11) * c_p6;
            r7_m5   <= c_p3 * asr32(r6_sq, 5'd13);
            r7_m3   <= r6_m3;
            r7_m4   <= r6_m4;
            r7_p    <= r6_p;

            r8_temp <= r7_temp;
            r8_b    <= asr32(w_b7, 5'd2) + (c_p4 << 16);
            r8_a    <= $signed(w_s5 + w_s4) >>> 18;
            r8_p    <= r7_p;

            r9_temp <= r8_temp;
            r9_m    <= (32'd32768 + r8_a) * c_p1;
            r9_b    <= r8_b;
            r9_p    <= r8_p;

            r10_temp <= r9_temp;
            r10_den  <= $signed(r9_m) >>> 15;
            r10_x    <= w_x10 - asr32(r9_b, 5'd12);

            r11_temp <= r10_temp;
            r11_den  <= r10_den;
            r11_pr   <= r10_x * 32'd3125;
        end
    end

    // dividend doubled before the divide when it fits, else quotient doubled
    t_div_tag         w_tag_in, w_tag_out;
    logic [DIV_W-1:0] w_num;
    logic             w_dv;
    logic [DIV_W-1:0] w_quot;

    assign w_tag_in.temp = r11_temp;
    assign w_tag_in.dbl  = r11_pr[31];
    assign w_tag_in.zero = (r11_den == 32'd0);
    assign w_num         = r11_pr[31] ? r11_pr : {r11_pr[30:0], 1'b0};

    tpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_v[10]),
        .i_num   (w_num),
        .i_den   (r11_den),
        .i_tag   (w_tag_in),
        .o_valid (w_dv),
        .o_quot  (w_quot),
        .o_tag   (w_tag_out)
    );

    logic [31:0] w_pr;
    assign w_pr = w_tag_out.dbl ? {w_quot[30:0], 1'b0} : w_quot;

    logic        r12_v, r13_v;
    t_div_tag    r12_tag, r13_tag;
    logic [31:0] r12_pr, r12_s, r12_m8;
    logic [31:0] r13_pr, r13_m9, r13_b;
    logic [31:0] w_fin;

    assign w_fin = r13_pr + asr32(asr32(r13_m9, 5'd12) + r13_b + c_p7, 5'd4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
            r13_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (w_adv) begin
            r12_v <= w_dv;
            r13_v <= r12_v;
            r_o_v <= r13_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r12_tag <= w_tag_out;
            r12_pr  <= w_pr;
            r12_s   <= (w_pr >> 3) * (w_pr >> 3);
            r12_m8  <= (w_pr >> 2) * c_p8;

            r13_tag <= r12_tag;
            r13_pr  <= r12_pr;
            r13_m9  <= c_p9 * (r12_s >> 13);
            r13_b   <= $signed(r12_m8) >>> 13;

            o_m_axis_tdata[31:0]  <= r13_tag.temp;
            o_m_axis_tdata[63:32] <= r13_tag.zero ? 32'd0 : w_fin;
            o_m_axis_tuser        <= r13_tag.zero;
        end
    end

    assign o_m_axis_tvalid = r_o_v;

endmodule
`default_nettype wire

@@ dv/tb_temp_pressure_compensation.sv @@
`timescale 1ns / 1ps

module tb_temp_pressure_compensation
    import tpc_pkg::*;
;

    localparam int SETTLE_CYCLES = 60;     // extra wait once every expected result has arrived
    localparam int STUCK_LIMIT   = 5000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 125;

    localparam int CFG_RESET   = 0;
    localparam int CFG_TYPICAL = 1;
    localparam int CFG_ONES    = 2;
    localparam int CFG_MAXPOS  = 3;
    localparam int CFG_MINNEG  = 4;
    localparam int CFG_RANDOM  = 5;
    localparam int CFG_NO_P1   = 6;

    typedef struct {
        logic [31:0] temp;
        logic [31:0] pres;
        logic        zero;
    } t_reading;

    typedef struct {
        int          cfg;
        logic [19:0] adc_t;
        logic [19:0] adc_p;
        bit          known;
        t_reading    want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [39:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_data;
    logic        m_user;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    temp_pressure_compensation i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // local copy of the calibration registers
    logic [63:0] cal_temp;
    logic [63:0] cal_pres_a;
    logic [63:0] cal_pres_b;
    logic [63:0] cal_p9;

    t_reading expected_readings[$];
    int sender_idle_pct;
    int recv_stall_pct;
    int n_samples;
    int n_checked;
    int n_zero_div;
    int n_fail;
    int n_shown;
    int stuck_cycles;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic t_reading compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
        logic [31:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, fine, sq, pr, x;
        t_reading r;
        at = {12'd0, adc_t};
        ap = {12'd0, adc_p};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = ext16(cal_temp[31:16]);
        t3 = ext16(cal_temp[47:32]);
        p1 = {16'd0, cal_pres_a[15:0]};
        p2 = ext16(cal_pres_a[31:16]);
        p3 = ext16(cal_pres_a[47:32]);
        p4 = ext16(cal_pres_a[63:48]);
        p5 = ext16(cal_pres_b[15:0]);
        p6 = ext16(cal_pres_b[31:16]);
        p7 = ext16(cal_pres_b[47:32]);
        p8 = ext16(cal_pres_b[63:48]);
        p9 = ext16(cal_p9[15:0]);

        x = (at >> 3) - (t1 << 1);
        x = x * t2;
        a = sra(x, 11);
        d = (at >> 4) - t1;
        x = d * d;
        x = sra(x, 12) * t3;
        b = sra(x, 14);
        fine = a + b;
        x = fine * 32'd5 + 32'd128;
        r.temp = sra(x, 8);

        a = sra(fine, 1) - 32'd64000;
        x = sra(a, 2);
        sq = x * x;
        b = sra(sq, 11) * p6;
        x = a * p5;
        b = b + (x << 1);
        b = sra(b, 2) + (p4 << 16);
        x = p3 * sra(sq, 13);
        d = p2 * a;
        a = sra(sra(x, 3) + sra(d, 1), 18);
        x = (32'd32768 + a) * p1;
        a = sra(x, 15);
        if (a == 32'd0) begin
            r.pres = 32'd0;
            r.zero = 1'b1;
        end else begin
            r.zero = 1'b0;
            pr = ((32'd1048576 - ap) - sra(b, 12)) * 32'd3125;
            if (pr < 32'h8000_0000) begin
                pr = (pr << 1) / a;
            end else begin
                pr = (pr / a) * 32'd2;
            end
            x = (pr >> 3) * (pr >> 3);
            x = p9 * (x >> 13);
            a = sra(x, 12);
            x = (pr >> 2) * p8;
            b = sra(x, 13);
            r.pres = pr + sra(a + b + p7, 4);
        end
        return r;
    endfunction

    // leaves the bus selected so that writes can follow back to back
    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_TEMP_COEFFS: cal_temp   = {16'd0, val[47:0]};
            REG_PRES_A:      cal_pres_a = val;
            REG_PRES_B:      cal_pres_b = val;
            REG_PRES_NINE:   cal_p9     = {48'd0, val[15:0]};
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic load_calibration(input int sel);
        logic [63:0] tc, pa, pb, p9;
        case (sel)
            CFG_TYPICAL: begin
                tc = {16'hFC18, 16'd26435, 16'd27504};
                pa = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
                pb = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
                p9 = 64'd6000;
            end
            CFG_ONES: begin
                tc = 64'h0000_FFFF_FFFF_FFFF;
                pa = '1;
                pb = '1;
                p9 = 64'hFFFF;
            end
            CFG_MAXPOS: begin
                tc = 64'h0000_7FFF_7FFF_FFFF;
                pa = 64'h7FFF_7FFF_7FFF_FFFF;
                pb = 64'h7FFF_7FFF_7FFF_7FFF;
                p9 = 64'h7FFF;
            end
            CFG_MINNEG: begin
                tc = 64'h0000_8000_8000_0000;
                pa = 64'h8000_8000_8000_0001;
                pb = 64'h8000_8000_8000_8000;
                p9 = 64'h8000;
            end
            CFG_NO_P1: begin
                tc = rand64();
                pa = {rand64() >> 16, 16'd0};
                pb = rand64();
                p9 = rand64();
            end
            CFG_RANDOM: begin
                tc = rand64();
                pa = rand64();
                pb = rand64();
                p9 = rand64();
            end
            default: begin
                tc = '0;
                pa = '0;
                pb = '0;
                p9 = '0;
            end
        endcase
        cfg_write(REG_TEMP_COEFFS, tc);
        cfg_write(REG_PRES_A, pa);
        cfg_write(REG_PRES_B, pb);
        cfg_write(REG_PRES_NINE, p9);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // registers only change once the pipeline has emptied out
    task automatic drain();
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [19:0] adc_t, input logic [19:0] adc_p,
                               input bit known, input t_reading want);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {adc_p, adc_t};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        expected_readings.push_back(known ? want : compensate(adc_t, adc_p));
        n_samples++;
    endtask

    task automatic set_idling(input int mode);
        sender_idle_pct = (mode == 1) ? 83 : (mode == 3) ? 13 : 0;
        recv_stall_pct  = (mode == 2) ? 83 : (mode == 3) ? 13 : 0;
    endtask

    // output side: random stall, compare and the stuck watchdog
    always @(posedge i_clk) begin
        t_reading want;
        logic [31:0] got_t, got_p;
        bool_check: begin
            if (!i_rst_n) begin
                m_ready      <= 1'b0;
                stuck_cycles <= 0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
                if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                    stuck_cycles <= 0;
                end else if (s_valid || expected_readings.size() != 0) begin
                    stuck_cycles <= stuck_cycles + 1;
                end
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
                    $display("temp_pressure_compensation verification failed");
                    $finish;
                end
                if (m_valid && m_ready) begin
                    got_t = m_data[31:0];
                    got_p = m_data[63:32];
                    if (expected_readings.size() == 0) begin
                        n_fail++;
                        if (n_shown < 10) begin
                            n_shown++;
                            $display("unexpected output beat: temp %0d pres %0d zero %0b",
                                     $signed(got_t), got_p, m_user);
                        end
                    end else begin
                        want = expected_readings.pop_front();
                        n_checked++;
                        if (want.zero) n_zero_div++;
                        if (got_t !== want.temp || got_p !== want.pres || m_user !== want.zero) begin
                            n_fail++;
                            if (n_shown < 10) begin
                                n_shown++;
                                $display("mismatch at beat %0d: temp %0d/%0d pres %0d/%0d zero %0b/%0b",
                                         n_checked, $signed(want.temp), $signed(got_t),
                                         want.pres, got_p, want.zero, m_user);
                            end
                        end
                    end
                end
            end
        end
    end

    initial begin
        t_dir_row rows[$];
        t_reading none;
        t_reading rst_out;
        int cur_cfg;
        int phase_cfg[RAND_PHASES];

        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cal_temp   = '0;
        cal_pres_a = '0;
        cal_pres_b = '0;
        cal_p9     = '0;
        n_samples  = 0;
        n_checked  = 0;
        n_zero_div = 0;
        n_fail     = 0;
        n_shown    = 0;
        none       = '{32'd0, 32'd0, 1'b0};
        // all-zero coefficients: temperature 0, divisor zero
        rst_out    = '{32'd0, 32'd0, 1'b1};
        set_idling(0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{CFG_RESET,   20'h00000, 20'h00000, 1'b1, rst_out},
            '{CFG_RESET,   20'hFFFFF, 20'hFFFFF, 1'b1, rst_out},
            '{CFG_RESET,   20'hFFFFF, 20'h00000, 1'b1, rst_out},
            '{CFG_RESET,   20'h00000, 20'hFFFFF, 1'b1, rst_out},
            '{CFG_TYPICAL, 20'd519888, 20'd415148, 1'b0, none},
            '{CFG_TYPICAL, 20'h00000, 20'h00000, 1'b0, none},
            '{CFG_TYPICAL, 20'hFFFFF, 20'hFFFFF, 1'b0, none},
            '{CFG_TYPICAL, 20'hFFFFF, 20'h00000, 1'b0, none},
            '{CFG_TYPICAL, 20'h00000, 20'hFFFFF, 1'b0, none},
            '{CFG_TYPICAL, 20'h80000, 20'h80000, 1'b0, none},
            '{CFG_TYPICAL, 20'h55555, 20'hAAAAA, 1'b0, none},
            '{CFG_ONES,    20'h00000, 20'h00000, 1'b0, none},
            '{CFG_ONES,    20'hFFFFF, 20'hFFFFF, 1'b0, none},
            '{CFG_MAXPOS,  20'h00000, 20'hFFFFF, 1'b0, none},
            '{CFG_MAXPOS,  20'hFFFFF, 20'h00000, 1'b0, none},
            '{CFG_MINNEG,  20'h00000, 20'h00000, 1'b0, none},
            '{CFG_MINNEG,  20'hFFFFF, 20'hFFFFF, 1'b0, none},
            '{CFG_NO_P1,   20'd519888, 20'd415148, 1'b0, none},
            '{CFG_NO_P1,   20'hFFFFF, 20'h00000, 1'b0, none}
        };
        cur_cfg = CFG_RESET;
        foreach (rows[i]) begin
            if (rows[i].cfg != cur_cfg) begin
                s_valid <= 1'b0;
                drain();
                load_calibration(rows[i].cfg);
                cur_cfg = rows[i].cfg;
            end
            send_sample(rows[i].adc_t, rows[i].adc_p, rows[i].known, rows[i].want);
        end

        phase_cfg = '{CFG_TYPICAL, CFG_RANDOM, CFG_ONES, CFG_RANDOM,
                      CFG_MAXPOS, CFG_NO_P1, CFG_MINNEG, CFG_RANDOM};
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            s_valid <= 1'b0;
            drain();
            load_calibration(phase_cfg[ph]);
            set_idling(ph % 4);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mostly full range, some near typical readings
                if ($urandom_range(3) == 0) begin
                    send_sample(20'd519888 + 20'($urandom_range(8191)) - 20'd4096,
                                20'd415148 + 20'($urandom_range(65535)) - 20'd32768,
                                1'b0, none);
                end else begin
                    send_sample(20'($urandom), 20'($urandom), 1'b0, none);
                end
            end
        end
        s_valid <= 1'b0;
        drain();

        n_fail += expected_readings.size();
        $display("%0d sample beats sent, %0d results checked, %0d with zero divisor",
                 n_samples, n_checked, n_zero_div);
        $display("calibration sets: reset, typical, all ones, extreme slices, random; %0d bad",
                 n_fail);
        if (n_fail == 0) begin
            $display("temp_pressure_compensation verification clean");
        end else begin
            $display("temp_pressure_compensation verification failed");
        end
        $finish;
    end

endmodule
